@@ rtl/rect_area_allocator_core_defines.svh @@
// Assertion macros shared by the rectangle allocator RTL.
`ifndef RECT_AREA_ALLOCATOR_CORE_DEFINES_SVH
`define RECT_AREA_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RAA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define RAA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ rtl/raa_pkg.sv @@
// Shared constants, types and helpers of the rectangle allocator.
package raa_pkg;
    localparam int MAX_SIDE  = 4096;
    localparam int MAX_FREE  = 64;
    localparam int SIDE_W    = 13;
    localparam int IDX_W     = $clog2(MAX_FREE);
    localparam int CNT_W     = IDX_W + 1;
    localparam int AREA_W    = 2 * SIDE_W;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [STAT_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 2'd1;

    typedef logic [SIDE_W-1:0] t_side;

    typedef struct packed {
        t_side left;
        t_side top;
        t_side right;
        t_side bottom;
    } t_rect;

    function automatic logic rect_inside(t_rect a, t_rect b);
        return (a.left >= b.left) && (a.top >= b.top) &&
               (a.right <= b.right) && (a.bottom <= b.bottom);
    endfunction

    function automatic t_side sat_side(t_side v);
        return (v > t_side'(MAX_SIDE)) ? t_side'(MAX_SIDE) : v;
    endfunction
endpackage

@@ rtl/raa_req_if.sv @@
// Request channel: size of the rectangle to reserve.
interface raa_req_if;
    logic                       valid;
    logic                       ready;
    logic [raa_pkg::SIDE_W-1:0] req_width;
    logic [raa_pkg::SIDE_W-1:0] req_height;

    modport source (output valid, output req_width, output req_height, input ready);
    modport sink   (input valid, input req_width, input req_height, output ready);
endinterface

@@ rtl/raa_rsp_if.sv @@
// Response channel: placement status and position.
interface raa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [raa_pkg::STAT_W-1:0] status;
    logic [raa_pkg::SIDE_W-1:0] pos_x;
    logic [raa_pkg::SIDE_W-1:0] pos_y;

    modport source (output valid, output status, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input status, input pos_x, input pos_y, output ready);
endinterface

@@ rtl/rect_area_allocator_core.sv @@
// Each request passes through a scan, a split of the overlapping entries, a pairwise prune
// and a copy-back of the survivors over the free list.
// One request at a time; a new request is taken once the previous response is gone.
// Synchronous active-low reset and a write to the atlas width or height while idle restart
// the list as one full-atlas rectangle; no clearing pass is needed.
`include "rect_area_allocator_core_defines.svh"

module rect_area_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    raa_req_if.sink                       i_req,
    raa_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [raa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [raa_pkg::SIDE_W-1:0]    i_cfg_data
);
    import raa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SC_RD  = 4'd1;
    localparam logic [3:0] S_SC_MUL = 4'd2;
    localparam logic [3:0] S_SC_CMP = 4'd3;
    localparam logic [3:0] S_SC_END = 4'd4;
    localparam logic [3:0] S_SP_RD  = 4'd5;
    localparam logic [3:0] S_SP_CHK = 4'd6;
    localparam logic [3:0] S_SP_PC  = 4'd7;
    localparam logic [3:0] S_PR_INI = 4'd8;
    localparam logic [3:0] S_PR_RDI = 4'd9;
    localparam logic [3:0] S_PR_GI  = 4'd10;
    localparam logic [3:0] S_PR_RDJ = 4'd11;
    localparam logic [3:0] S_PR_CMP = 4'd12;
    localparam logic [3:0] S_CP_RD  = 4'd13;
    localparam logic [3:0] S_CP_WR  = 4'd14;

    // free list, survivors of the split, appended pieces
    t_rect mem_m [MAX_FREE];
    t_rect mem_w [MAX_FREE];
    t_rect mem_p [MAX_FREE];

    logic [3:0]          r_state;
    t_side               r_aw, r_ah;
    logic                r_m0_dflt;
    logic [CNT_W-1:0]    r_count;
    t_side               r_w, r_h;
    logic [CNT_W-1:0]    r_k;
    logic                r_found;
    logic [AREA_W-1:0]   r_best;
    t_side               r_bl, r_bt;
    logic [AREA_W-1:0]   r_prod;
    logic                r_fit;
    t_side               r_cl, r_ct;
    logic [SIDE_W:0]     r_rr, r_rb;
    t_rect               r_o;
    logic [1:0]          r_piece;
    logic [CNT_W-1:0]    r_wcnt, r_pcnt, r_len, r_i, r_j, r_dst;
    logic [MAX_FREE-1:0] r_valid;
    t_rect               r_a;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    t_side               r_px, r_py;

    t_rect               r_m_rdata, r_w_rdata, r_p_rdata;
    logic                r_m_sel0, r_rsel;

    logic [IDX_W-1:0]    m_raddr;
    logic [CNT_W-1:0]    v_idx;
    logic [CNT_W-1:0]    p_off;
    t_rect               m_data, v_data;
    logic                m_we, w_we, p_we;
    t_rect               w_wdata, p_wdata;
    t_side               fw, fh;
    logic                bad;
    logic                ovl;
    logic                pc_cond;
    t_rect               pc_rect;
    logic [CNT_W:0]      live;
    logic                k_last;

    assign i_req.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.pos_x  = r_px;
    assign o_rsp.pos_y  = r_py;

    assign m_raddr = r_k[IDX_W-1:0];
    assign v_idx   = (r_state == S_PR_RDI) ? r_i :
                     (r_state == S_PR_RDJ) ? r_j : r_i;
    assign p_off   = v_idx - r_wcnt;

    assign m_data = r_m_sel0 ? t_rect'{left: '0, top: '0, right: r_aw, bottom: r_ah}
                             : r_m_rdata;
    assign v_data = r_rsel ? r_p_rdata : r_w_rdata;

    assign bad = (m_data.right < m_data.left) || (m_data.bottom < m_data.top);
    assign fw  = m_data.right - m_data.left;
    assign fh  = m_data.bottom - m_data.top;

    assign ovl = (r_rr > {1'b0, m_data.left}) && (r_bl < m_data.right) &&
                 (r_rb > {1'b0, m_data.top}) && (r_bt < m_data.bottom);

    assign live   = {1'b0, r_wcnt} + ({1'b0, r_count} - {1'b0, r_k}) + {1'b0, r_pcnt};
    assign k_last = (r_k + 1'b1) == r_count;

    // piece order: right, left, bottom, top
    always_comb begin
        pc_rect = r_o;
        pc_cond = 1'b0;
        unique case (r_piece)
            2'd0: begin
                pc_cond      = r_rr < {1'b0, r_o.right};
                pc_rect.left = r_rr[SIDE_W-1:0];
            end
            2'd1: begin
                pc_cond       = r_bl > r_o.left;
                pc_rect.right = r_bl;
            end
            2'd2: begin
                pc_cond     = r_rb < {1'b0, r_o.bottom};
                pc_rect.top = r_rb[SIDE_W-1:0];
            end
            default: begin
                pc_cond        = r_bt > r_o.top;
                pc_rect.bottom = r_bt;
            end
        endcase
    end

    assign m_we    = (r_state == S_CP_WR);
    assign w_we    = (r_state == S_SP_CHK) && !ovl;
    assign w_wdata = m_data;
    assign p_we    = (r_state == S_SP_PC) && pc_cond && (live < (CNT_W+1)'(MAX_FREE));
    assign p_wdata = pc_rect;

    always_ff @(posedge i_clk) begin
        r_m_rdata <= mem_m[m_raddr];
        r_w_rdata <= mem_w[v_idx[IDX_W-1:0]];
        r_p_rdata <= mem_p[p_off[IDX_W-1:0]];
        r_m_sel0  <= r_m0_dflt && (m_raddr == '0);
        r_rsel    <= v_idx >= r_wcnt;
        if (m_we) begin
            mem_m[r_dst[IDX_W-1:0]] <= v_data;
        end
        if (w_we) begin
            mem_w[r_wcnt[IDX_W-1:0]] <= w_wdata;
        end
        if (p_we) begin
            mem_p[r_pcnt[IDX_W-1:0]] <= p_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_aw        <= t_side'(MAX_SIDE);
            r_ah        <= t_side'(MAX_SIDE);
            r_m0_dflt   <= 1'b1;
            r_count     <= CNT_W'(1);
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_k         <= '0;
            r_wcnt      <= '0;
            r_pcnt      <= '0;
            r_valid     <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we && (i_cfg_idx == CFG_ATLAS_W || i_cfg_idx == CFG_ATLAS_H)) begin
                        if (i_cfg_idx == CFG_ATLAS_W) begin
                            r_aw <= sat_side(i_cfg_data);
                        end else begin
                            r_ah <= sat_side(i_cfg_data);
                        end
                        r_m0_dflt <= 1'b1;
                        r_count   <= CNT_W'(1);
                    end
                    if (i_req.valid && !r_out_valid) begin
                        r_w     <= i_req.req_width;
                        r_h     <= i_req.req_height;
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_wcnt  <= '0;
                        r_pcnt  <= '0;
                        if (r_count == '0) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_NOFIT;
                            r_px        <= '0;
                            r_py        <= '0;
                        end else begin
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_SC_RD: begin
                    r_state <= S_SC_MUL;
                end
                S_SC_MUL: begin
                    r_prod  <= AREA_W'(fw) * AREA_W'(fh);
                    r_fit   <= !bad && (fw >= r_w) && (fh >= r_h);
                    r_cl    <= m_data.left;
                    r_ct    <= m_data.top;
                    r_state <= S_SC_CMP;
                end
                S_SC_CMP: begin
                    if (r_fit && (!r_found || r_prod < r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= r_prod;
                        r_bl    <= r_cl;
                        r_bt    <= r_ct;
                    end
                    if (k_last) begin
                        r_state <= S_SC_END;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_END: begin
                    r_k <= '0;
                    r_rr <= {1'b0, r_bl} + {1'b0, r_w};
                    r_rb <= {1'b0, r_bt} + {1'b0, r_h};
                    if (!r_found) begin
                        r_out_valid <= 1'b1;
                        r_status    <= ST_NOFIT;
                        r_px        <= '0;
                        r_py        <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_SP_RD;
                    end
                end
                S_SP_RD: begin
                    r_state <= S_SP_CHK;
                end
                S_SP_CHK: begin
                    r_o <= m_data;
                    if (ovl) begin
                        r_piece <= 2'd0;
                        r_state <= S_SP_PC;
                    end else begin
                        r_wcnt <= r_wcnt + 1'b1;
                        if (k_last) begin
                            r_state <= S_PR_INI;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_SP_RD;
                        end
                    end
                end
                S_SP_PC: begin
                    if (pc_cond && !(live < (CNT_W+1)'(MAX_FREE))) begin
                        // list would overflow: drop the work copy
                        r_out_valid <= 1'b1;
                        r_status    <= ST_FULL;
                        r_px        <= '0;
                        r_py        <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        if (pc_cond) begin
                            r_pcnt <= r_pcnt + 1'b1;
                        end
                        if (r_piece == 2'd3) begin
                            if (k_last) begin
                                r_state <= S_PR_INI;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_SP_RD;
                            end
                        end else begin
                            r_piece <= r_piece + 1'b1;
                        end
                    end
                end
                S_PR_INI: begin
                    r_len   <= r_wcnt + r_pcnt;
                    r_valid <= '1;
                    r_i     <= '0;
                    r_state <= S_PR_RDI;
                end
                S_PR_RDI: begin
                    if (r_i == r_len) begin
                        r_i     <= '0;
                        r_dst   <= '0;
                        r_state <= S_CP_RD;
                    end else if (!r_valid[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j     <= r_i + 1'b1;
                        r_state <= S_PR_GI;
                    end
                end
                S_PR_GI: begin
                    r_a     <= v_data;
                    r_state <= S_PR_RDJ;
                end
                S_PR_RDJ: begin
                    if (r_j == r_len) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PR_RDI;
                    end else if (!r_valid[r_j[IDX_W-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_PR_CMP;
                    end
                end
                S_PR_CMP: begin
                    priority if (rect_inside(r_a, v_data)) begin
                        r_valid[r_i[IDX_W-1:0]] <= 1'b0;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PR_RDI;
                    end else if (rect_inside(v_data, r_a)) begin
                        r_valid[r_j[IDX_W-1:0]] <= 1'b0;
                        r_j     <= r_j + 1'b1;
                        r_state <= S_PR_RDJ;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_PR_RDJ;
                    end
                end
                S_CP_RD: begin
                    if (r_i == r_len) begin
                        r_count     <= r_dst;
                        r_m0_dflt   <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_status    <= ST_PLACED;
                        r_px        <= r_bl;
                        r_py        <= r_bt;
                        r_state     <= S_IDLE;
                    end else if (!r_valid[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_CP_WR;
                    end
                end
                S_CP_WR: begin
                    r_dst   <= r_dst + 1'b1;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_CP_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RAA_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_W'(MAX_FREE))
    `RAA_ASSERT_NOW(a_work_cap, r_state != S_IDLE, ({1'b0, r_wcnt} + {1'b0, r_pcnt}) <= (CNT_W+1)'(MAX_FREE))
    `RAA_ASSERT_NOW(a_nopos, o_rsp.valid && o_rsp.status != ST_PLACED, o_rsp.pos_x == '0 && o_rsp.pos_y == '0)
    `RAA_ASSERT_NEXT(a_one_rsp, i_req.valid && i_req.ready, !o_rsp.valid || r_count == '0)

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the rectangle area allocator: random and directed requests.
module tb_top;
    import raa_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 5000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [STAT_W-1:0] status;
        t_side             pos_x;
        t_side             pos_y;
    } t_placement;

    typedef struct {
        t_side w;
        t_side h;
    } t_size;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIDE_W-1:0]    i_cfg_data;

    raa_req_if req_ch ();
    raa_rsp_if rsp_ch ();

    rect_area_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the allocator state
    t_side      atlas_w;
    t_side      atlas_h;
    t_rect      free_list[MAX_FREE];
    int         free_n;
    t_rect      scratch[MAX_FREE];
    int         scratch_n;

    t_size      pending_sizes[$];
    t_placement placements_due[$];
    int         mismatches;
    int         idle_cycles;
    int         req_gap;
    int         rsp_stall;
    bit         no_gaps;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void restart_free_list();
        free_list[0] = '{left: '0, top: '0, right: atlas_w, bottom: atlas_h};
        free_n = 1;
    endfunction

    function automatic bit covered_by(t_rect a, t_rect b);
        return a.left >= b.left && a.top >= b.top && a.right <= b.right &&
               a.bottom <= b.bottom;
    endfunction

    function automatic void scratch_drop(int idx);
        for (int m = idx; m < scratch_n - 1; m++)
            scratch[m] = scratch[m + 1];
        scratch_n--;
    endfunction

    function automatic bit scratch_append(t_rect r);
        if (scratch_n >= MAX_FREE)
            return 1'b0;
        scratch[scratch_n] = r;
        scratch_n++;
        return 1'b1;
    endfunction

    function automatic t_placement place_rect(t_side w, t_side h);
        t_placement res;
        int         best;
        bit         found;
        logic [AREA_W-1:0] best_area;
        logic [AREA_W-1:0] a;
        t_side      fw;
        t_side      fh;
        t_rect      resv;
        t_rect      o;
        t_rect      p;
        int         k;
        int         i;
        int         j;
        bit         dropped;
        bit         ok;
        res = '{status: ST_NOFIT, pos_x: '0, pos_y: '0};
        best = 0;
        found = 1'b0;
        best_area = '0;
        for (k = 0; k < free_n; k++) begin
            if (free_list[k].right < free_list[k].left ||
                free_list[k].bottom < free_list[k].top)
                continue;
            fw = free_list[k].right - free_list[k].left;
            fh = free_list[k].bottom - free_list[k].top;
            if (fw >= w && fh >= h) begin
                a = fw * fh;
                if (!found || a < best_area) begin
                    found = 1'b1;
                    best = k;
                    best_area = a;
                end
            end
        end
        if (!found)
            return res;
        resv.left   = free_list[best].left;
        resv.top    = free_list[best].top;
        resv.right  = free_list[best].left + w;
        resv.bottom = free_list[best].top + h;
        scratch_n = free_n;
        for (k = 0; k < free_n; k++)
            scratch[k] = free_list[k];
        k = 0;
        while (k < scratch_n) begin
            o = scratch[k];
            if (resv.right > o.left && resv.left < o.right &&
                resv.bottom > o.top && resv.top < o.bottom) begin
                ok = 1'b1;
                if (resv.right < o.right) begin
                    p = o; p.left = resv.right; ok = ok && scratch_append(p);
                end
                if (ok && resv.left > o.left) begin
                    p = o; p.right = resv.left; ok = ok && scratch_append(p);
                end
                if (ok && resv.bottom < o.bottom) begin
                    p = o; p.top = resv.bottom; ok = ok && scratch_append(p);
                end
                if (ok && resv.top > o.top) begin
                    p = o; p.bottom = resv.top; ok = ok && scratch_append(p);
                end
                // Overflow leaves the live list untouched
                if (!ok) begin
                    res.status = ST_FULL;
                    return res;
                end
                scratch_drop(k);
            end else begin
                k++;
            end
        end
        i = 0;
        while (i < scratch_n) begin
            dropped = 1'b0;
            j = i + 1;
            while (j < scratch_n) begin
                if (covered_by(scratch[i], scratch[j])) begin
                    scratch_drop(i);
                    dropped = 1'b1;
                    break;
                end
                if (covered_by(scratch[j], scratch[i]))
                    scratch_drop(j);
                else
                    j++;
            end
            if (!dropped)
                i++;
        end
        for (k = 0; k < scratch_n; k++)
            free_list[k] = scratch[k];
        free_n = scratch_n;
        res = '{status: ST_PLACED, pos_x: resv.left, pos_y: resv.top};
        return res;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        t_size      nxt;
        t_placement due_p;
        if (!i_rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.req_width  <= '0;
            req_ch.req_height <= '0;
            req_gap           <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                due_p = place_rect(req_ch.req_width, req_ch.req_height);
                placements_due = {placements_due, due_p};
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap > 0) begin
                    req_gap      <= req_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_sizes.size() > 0) begin
                    nxt = pending_sizes.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_width  <= nxt.w;
                    req_ch.req_height <= nxt.h;
                    req_gap <= no_gaps ? 0 : $urandom_range(0, 8);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and checker
    always @(posedge i_clk) begin
        t_placement exp_p;
        int         stall;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (placements_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: status %0d x %0d y %0d",
                                 rsp_ch.status, rsp_ch.pos_x, rsp_ch.pos_y);
                end else begin
                    exp_p = placements_due.pop_front();
                    if (rsp_ch.status !== exp_p.status || rsp_ch.pos_x !== exp_p.pos_x ||
                        rsp_ch.pos_y !== exp_p.pos_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status %0d x %0d y %0d, got %0d %0d %0d",
                                     exp_p.status, exp_p.pos_x, exp_p.pos_y,
                                     rsp_ch.status, rsp_ch.pos_x, rsp_ch.pos_y);
                    end
                end
                stall = no_gaps ? 0 : $urandom_range(0, 8);
                rsp_stall    <= stall;
                rsp_ch.ready <= (stall == 0);
            end else if (rsp_stall > 0) begin
                rsp_stall    <= rsp_stall - 1;
                rsp_ch.ready <= (rsp_stall == 1);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || i_cfg_we ||
            !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_size(int w, int h);
        t_size sz;
        sz.w = t_side'(w);
        sz.h = t_side'(h);
        pending_sizes = {pending_sizes, sz};
    endtask

    task automatic wait_idle();
        while (pending_sizes.size() > 0 || placements_due.size() > 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= t_side'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ATLAS_W || idx == CFG_ATLAS_H) begin
            if (idx == CFG_ATLAS_W)
                atlas_w = (t_side'(value) > t_side'(MAX_SIDE)) ? t_side'(MAX_SIDE)
                                                                : t_side'(value);
            else
                atlas_h = (t_side'(value) > t_side'(MAX_SIDE)) ? t_side'(MAX_SIDE)
                                                                : t_side'(value);
            restart_free_list();
        end
        // hold the enable low before the next write
        @(posedge i_clk);
    endtask

    initial begin
        int aw;
        int ah;
        int lim;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        mismatches  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        atlas_w     = t_side'(MAX_SIDE);
        atlas_h     = t_side'(MAX_SIDE);
        restart_free_list();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes on the full atlas
        add_size(8191, 1);
        add_size(1, 8191);
        add_size(4097, 4096);
        add_size(0, 0);
        add_size(0, 4096);
        add_size(4096, 0);
        add_size(100, 50);
        add_size(2730, 5461);
        add_size(4096, 4096);
        add_size(4096, 4096);
        add_size(0, 0);
        add_size(1, 1);
        wait_idle();
        // Unknown indexes are ignored; oversized values saturate
        write_reg(CFG_SPARE_A, 17);
        write_reg(CFG_SPARE_B, 0);
        write_reg(CFG_ATLAS_W, 8191);
        write_reg(CFG_ATLAS_H, 5000);
        add_size(4096, 4096);
        add_size(1, 1);
        wait_idle();
        // Empty atlas takes only zero-sized requests
        write_reg(CFG_ATLAS_W, 0);
        write_reg(CFG_ATLAS_H, 0);
        add_size(0, 0);
        add_size(0, 0);
        add_size(1, 0);
        add_size(0, 1);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 3)
                0: begin aw = $urandom_range(0, 8191); ah = $urandom_range(0, 8191); end
                1: begin aw = $urandom_range(32, 160); ah = $urandom_range(32, 160); end
                default: begin aw = MAX_SIDE; ah = MAX_SIDE; end
            endcase
            write_reg(CFG_ATLAS_W, aw);
            write_reg(CFG_ATLAS_H, ah);
            no_gaps = (ph == 3);
            lim = (aw > MAX_SIDE) ? MAX_SIDE : aw;
            lim = (lim < 8) ? 8 : lim / 6;
            for (int n = 0; n < 18; n++) begin
                if ($urandom_range(0, 9) == 0)
                    add_size($urandom_range(0, 8191), $urandom_range(0, 8191));
                else if ($urandom_range(0, 9) == 0)
                    add_size(0, $urandom_range(0, lim));
                else
                    add_size($urandom_range(1, lim), $urandom_range(1, lim));
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (placements_due.size() > 0)
            mismatches++;
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
